// ===== design/pbo_pkg.sv =====
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared types, constants and the cosine table generator of the PolyBLEP
// oscillator.
// ----------------------------------------------------------------------------
package pbo_pkg;

    localparam int DEF_SINE_TABLE_DEPTH = 512;
    localparam int DEF_PHASE_BITS       = 24;

    localparam int INC_W    = 23;
    localparam int PWM_W    = 16;
    localparam int WAVE_W   = 7;
    localparam int SAMPLE_W = 18;
    localparam int ROM_W    = 17;
    localparam int BLEP_W   = 17;
    localparam int QUO_W    = 15;
    localparam int R_W      = 16;
    localparam int SQ_W     = 31;
    localparam int CNT_W    = 4;

    localparam logic [WAVE_W-1:0] WAVE_RESET       = 7'd127;
    localparam logic [WAVE_W-1:0] SQUARE_THRESHOLD = 7'd84;
    localparam logic [WAVE_W-1:0] SAW_THRESHOLD    = 7'd42;

    localparam logic signed [PWM_W-1:0] PWM_LIMIT = 16'sd32440;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLEP1,
        ST_BLEP2,
        ST_SINE_RDA,
        ST_SINE_RDB,
        ST_SINE_MUL,
        ST_FINISH
    } osc_state_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_SQR
    } blep_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } blep_status_t;

    // floor(dividend / divisor) by shift and subtract
    function automatic longint unsigned udiv(longint unsigned dividend,
                                             longint unsigned divisor);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((dividend >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= divisor)
            begin
                rem = rem - divisor;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // cos(2*pi*k/depth) in Q2.15, Taylor series in Q2.30
    function automatic logic signed [ROM_W-1:0] cos_entry(int unsigned k, int unsigned depth);
        longint unsigned d;
        longint unsigned m;
        longint unsigned num;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        bit              neg;
        d   = longint'(depth);
        m   = longint'(k) - udiv(longint'(k), d) * d;
        neg = 1'b0;
        if (2 * m > d)
            m = d - m;
        num = 2 * m;
        if (4 * m > d)
        begin
            num = d - 2 * m;
            neg = 1'b1;
        end
        x    = udiv(PI_Q30 * num, d);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 8; n++)
        begin
            term = (term * x2) >> 30;
            term = udiv(term, longint'((2 * n - 1) * (2 * n)));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
        begin
            neg = !neg;
            sum = -sum;
        end
        v = (sum + 16384) >>> 15;
        return ROM_W'(neg ? -v : v);
    endfunction

endpackage

// ===== design/pbo_cos_rom.sv =====
// ----------------------------------------------------------------------------
// pbo_cos_rom
// Cosine table of DEPTH+1 Q2.15 entries with registered read.
// ----------------------------------------------------------------------------
module pbo_cos_rom #(
    parameter int DEPTH  = pbo_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic [ADDR_W-1:0]                 addr,
    output logic signed [pbo_pkg::ROM_W-1:0]  rd_data
);

    logic signed [pbo_pkg::ROM_W-1:0] rom_tab [DEPTH+1];

    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_rom
        localparam logic signed [pbo_pkg::ROM_W-1:0] ENTRY = pbo_pkg::cos_entry(k, DEPTH);
        assign rom_tab[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (32'(addr) <= 32'(DEPTH))
            rd_data <= rom_tab[addr];
        else
            rd_data <= '0;
    end

endmodule

// ===== design/pbo_blep.sv =====
// ----------------------------------------------------------------------------
// pbo_blep
// PolyBLEP correction: bit-serial restoring divider followed by a
// bit-serial squarer.
// ----------------------------------------------------------------------------
module pbo_blep #(
    parameter int PHASE_BITS = pbo_pkg::DEF_PHASE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [PHASE_BITS-1:0]              phase,
    input  logic [PHASE_BITS-1:0]              incr,
    output pbo_pkg::blep_status_t              status,
    output logic signed [pbo_pkg::BLEP_W-1:0]  result
);

    localparam int PB = PHASE_BITS;

    pbo_pkg::blep_state_t state_reg, state_next;

    logic [PB-1:0]                   rem_reg;
    logic [PB-1:0]                   dvs_reg;
    logic [pbo_pkg::QUO_W-1:0]       quo_reg;
    logic                            neg_reg;
    logic [pbo_pkg::CNT_W-1:0]       cnt_reg;
    logic [pbo_pkg::R_W-1:0]         r_reg;
    logic [pbo_pkg::R_W-1:0]         mb_reg;
    logic [pbo_pkg::SQ_W-1:0]        acc_reg;
    logic signed [pbo_pkg::BLEP_W-1:0] res_reg;
    logic                            done_reg;

    logic [PB:0]                     sum_pd;
    logic                            below;
    logic                            above;
    logic                            go_div;
    logic [PB:0]                     rem2;
    logic                            ge;
    logic [PB-1:0]                   rem_next;
    logic [pbo_pkg::QUO_W-1:0]       quo_next;
    logic [pbo_pkg::R_W-1:0]         r_next;
    logic [pbo_pkg::SQ_W-1:0]        acc_next;
    logic [pbo_pkg::R_W-1:0]         sq_res;

    logic                            load_div;
    logic                            load_zero;
    logic                            last_div;
    logic                            last_sqr;

    assign sum_pd = {1'b0, phase} + {1'b0, incr};
    assign below  = phase < incr;
    assign above  = sum_pd[PB] && (|sum_pd[PB-1:0]);
    assign go_div = (|incr) && (below || above);

    assign rem2     = {rem_reg, 1'b0};
    assign ge       = rem2 >= {1'b0, dvs_reg};
    assign rem_next = ge ? PB'(rem2 - {1'b0, dvs_reg}) : rem2[PB-1:0];
    assign quo_next = {quo_reg[pbo_pkg::QUO_W-2:0], ge};
    assign r_next   = 16'h8000 - {1'b0, quo_next};

    assign acc_next = {acc_reg[pbo_pkg::SQ_W-2:0], 1'b0}
                    + (mb_reg[pbo_pkg::R_W-1] ? pbo_pkg::SQ_W'(r_reg) : '0);
    assign sq_res   = acc_next[pbo_pkg::SQ_W-1 -: pbo_pkg::R_W];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbo_pkg::BS_IDLE:
            begin
                if (start && go_div)
                    state_next = pbo_pkg::BS_DIV;
            end
            pbo_pkg::BS_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = pbo_pkg::BS_SQR;
            end
            pbo_pkg::BS_SQR:
            begin
                if (cnt_reg == '0)
                    state_next = pbo_pkg::BS_IDLE;
            end
            default:
                state_next = pbo_pkg::BS_IDLE;
        endcase
    end

    always_comb
    begin
        load_div  = 1'b0;
        load_zero = 1'b0;
        last_div  = 1'b0;
        last_sqr  = 1'b0;
        case (state_reg)
            pbo_pkg::BS_IDLE:
            begin
                load_div  = start && go_div;
                load_zero = start && !go_div;
            end
            pbo_pkg::BS_DIV:
                last_div = cnt_reg == '0;
            pbo_pkg::BS_SQR:
                last_sqr = cnt_reg == '0;
            default:
            begin
                load_div = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbo_pkg::BS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= load_zero || last_sqr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_div)
        begin
            rem_reg <= below ? phase : PB'(~phase + 1'b1);
            neg_reg <= below;
            dvs_reg <= incr;
            quo_reg <= '0;
            cnt_reg <= pbo_pkg::CNT_W'(pbo_pkg::QUO_W - 1);
        end
        else if (state_reg == pbo_pkg::BS_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (last_div)
            begin
                r_reg   <= r_next;
                mb_reg  <= r_next;
                acc_reg <= '0;
                cnt_reg <= pbo_pkg::CNT_W'(pbo_pkg::R_W - 1);
            end
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
        else if (state_reg == pbo_pkg::BS_SQR)
        begin
            acc_reg <= acc_next;
            mb_reg  <= {mb_reg[pbo_pkg::R_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (load_zero)
            res_reg <= '0;
        else if (last_sqr)
            res_reg <= neg_reg ? -signed'({1'b0, sq_res}) : signed'({1'b0, sq_res});
    end

    assign status.busy = state_reg != pbo_pkg::BS_IDLE;
    assign status.done = done_reg;
    assign result      = res_reg;

endmodule

// ===== design/polyblep_oscillator.sv =====
// ----------------------------------------------------------------------------
// polyblep_oscillator
// Band-limited oscillator: PolyBLEP square and sawtooth, interpolated cosine.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_stall    phase_increment, pulse_width_mod
//   output    out        out_valid/out_stall  sample_out
//   config    in         cfg_write_en         cfg_write_data
//
// Cosine reads two adjacent table entries and interpolates between them. Sawtooth
// applies one PolyBLEP correction and square two; a correction whose phase falls
// in a transition region runs a bit-serial divider and then a bit-serial squarer.
// One transaction is worked on at a time; in_stall is high while it runs.
// A finished sample waits in the output register while out_stall is high.
// Reset clears the phase and selects the square waveform.
// ----------------------------------------------------------------------------
module polyblep_oscillator #(
    parameter int SINE_TABLE_DEPTH = pbo_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = pbo_pkg::DEF_PHASE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pbo_pkg::INC_W-1:0]            phase_increment,
    input  logic signed [pbo_pkg::PWM_W-1:0]     pulse_width_mod,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pbo_pkg::SAMPLE_W-1:0]  sample_out,
    input  logic                                 cfg_write_en,
    input  logic [pbo_pkg::WAVE_W-1:0]           cfg_write_data
);

    localparam int PB     = PHASE_BITS;
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int POS_W  = PB + ADDR_W;
    localparam int EXT_W  = (PB > pbo_pkg::INC_W) ? PB : pbo_pkg::INC_W;
    localparam int DIFF_W = pbo_pkg::ROM_W + 1;
    localparam int PROD_W = DIFF_W + PB + 1;
    localparam int V_W    = 20;
    localparam logic [PB:0] HALF = (PB + 1)'(1) << (PB - 1);

    pbo_pkg::osc_state_t state_reg, state_next;

    logic [PB-1:0]                       phase_reg;
    logic [pbo_pkg::WAVE_W-1:0]          wave_reg;
    logic [PB-1:0]                       p_reg;
    logic [PB-1:0]                       d_reg;
    logic [PB-1:0]                       pw_reg;
    logic signed [pbo_pkg::BLEP_W-1:0]   b1_reg;
    logic signed [pbo_pkg::BLEP_W-1:0]   b2_reg;
    logic [ADDR_W-1:0]                   i_reg;
    logic [PB-1:0]                       f_reg;
    logic signed [pbo_pkg::ROM_W-1:0]    a_reg;
    logic signed [PROD_W-1:0]            prod_reg;
    logic                                out_valid_reg;
    logic signed [pbo_pkg::SAMPLE_W-1:0] out_data_reg;

    logic                                accept;
    logic                                is_square;
    logic                                is_saw;
    logic [EXT_W-1:0]                    inc_ext;
    logic [PB-1:0]                       d_in;
    logic signed [pbo_pkg::PWM_W-1:0]    pwm_c;
    logic [PB:0]                         pw_full;
    logic [POS_W-1:0]                    pos;

    logic                                blep_start;
    logic [PB-1:0]                       blep_p;
    logic [PB-1:0]                       blep_d;
    pbo_pkg::blep_status_t               blep_status;
    logic signed [pbo_pkg::BLEP_W-1:0]   blep_result;

    logic [ADDR_W-1:0]                   rom_addr;
    logic signed [pbo_pkg::ROM_W-1:0]    rom_data;
    logic signed [DIFF_W-1:0]            diff;

    logic                                out_load;
    logic signed [PROD_W-1:0]            prod_sh;
    logic signed [DIFF_W-1:0]            interp;
    logic signed [V_W-1:0]               lvl;
    logic signed [V_W-1:0]               v_sum;
    logic signed [pbo_pkg::SAMPLE_W-1:0] v_sat;

    assign accept    = in_valid && !in_stall;
    assign is_square = wave_reg > pbo_pkg::SQUARE_THRESHOLD;
    assign is_saw    = !is_square && (wave_reg > pbo_pkg::SAW_THRESHOLD);

    assign inc_ext = EXT_W'(phase_increment);
    assign d_in    = inc_ext[PB-1:0];

    always_comb
    begin
        if (pulse_width_mod > pbo_pkg::PWM_LIMIT)
            pwm_c = pbo_pkg::PWM_LIMIT;
        else if (pulse_width_mod < -pbo_pkg::PWM_LIMIT)
            pwm_c = -pbo_pkg::PWM_LIMIT;
        else
            pwm_c = pulse_width_mod;
    end

    assign pw_full = HALF + ((PB + 1)'(pwm_c) << (PB - 16));
    assign pos     = POS_W'(phase_reg) * POS_W'(SINE_TABLE_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbo_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (is_square || is_saw) ? pbo_pkg::ST_BLEP1
                                                       : pbo_pkg::ST_SINE_RDA;
            end
            pbo_pkg::ST_BLEP1:
            begin
                if (blep_status.done)
                    state_next = is_square ? pbo_pkg::ST_BLEP2 : pbo_pkg::ST_FINISH;
            end
            pbo_pkg::ST_BLEP2:
            begin
                if (blep_status.done)
                    state_next = pbo_pkg::ST_FINISH;
            end
            pbo_pkg::ST_SINE_RDA:
                state_next = pbo_pkg::ST_SINE_RDB;
            pbo_pkg::ST_SINE_RDB:
                state_next = pbo_pkg::ST_SINE_MUL;
            pbo_pkg::ST_SINE_MUL:
                state_next = pbo_pkg::ST_FINISH;
            pbo_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = pbo_pkg::ST_IDLE;
            end
            default:
                state_next = pbo_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        blep_start = 1'b0;
        blep_p     = phase_reg;
        blep_d     = d_in;
        rom_addr   = i_reg + 1'b1;
        out_load   = 1'b0;
        case (state_reg)
            pbo_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                blep_start = in_valid && (is_square || is_saw);
            end
            pbo_pkg::ST_BLEP1:
            begin
                blep_start = blep_status.done && is_square;
                blep_p     = p_reg - pw_reg;
                blep_d     = d_reg;
            end
            pbo_pkg::ST_SINE_RDA:
                rom_addr = i_reg;
            pbo_pkg::ST_FINISH:
                out_load = !out_valid_reg || !out_stall;
            default:
                in_stall = 1'b1;
        endcase
    end

    pbo_blep #(
        .PHASE_BITS (PHASE_BITS)
    ) u_blep (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (blep_start),
        .phase  (blep_p),
        .incr   (blep_d),
        .status (blep_status),
        .result (blep_result)
    );

    pbo_cos_rom #(
        .DEPTH  (SINE_TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_cos_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    assign diff    = DIFF_W'(rom_data) - DIFF_W'(a_reg);
    assign prod_sh = prod_reg >>> PB;
    assign interp  = prod_sh[DIFF_W-1:0];
    assign lvl     = (p_reg <= pw_reg) ? 20'sd32768 : -20'sd32768;

    always_comb
    begin
        if (is_square)
            v_sum = lvl + V_W'(b1_reg) - V_W'(b2_reg);
        else if (is_saw)
            v_sum = 20'sd32768 - signed'(V_W'({p_reg[PB-1 -: 15], 1'b0})) + V_W'(b1_reg);
        else
            v_sum = V_W'(a_reg) + V_W'(interp);
        if (v_sum > 20'sd131071)
            v_sat = 18'sh1FFFF;
        else if (v_sum < -20'sd131072)
            v_sat = 18'sh20000;
        else
            v_sat = v_sum[pbo_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbo_pkg::ST_IDLE;
            phase_reg     <= '0;
            wave_reg      <= pbo_pkg::WAVE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                phase_reg <= PB'(phase_reg + d_in);
            if (cfg_write_en)
                wave_reg <= cfg_write_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg  <= phase_reg;
            d_reg  <= d_in;
            pw_reg <= pw_full[PB-1:0];
            i_reg  <= pos[POS_W-1:PB];
            f_reg  <= pos[PB-1:0];
        end
        if (state_reg == pbo_pkg::ST_BLEP1 && blep_status.done)
            b1_reg <= blep_result;
        if (state_reg == pbo_pkg::ST_BLEP2 && blep_status.done)
            b2_reg <= blep_result;
        if (state_reg == pbo_pkg::ST_SINE_RDB)
            a_reg <= rom_data;
        if (state_reg == pbo_pkg::ST_SINE_MUL)
            prod_reg <= PROD_W'(diff) * PROD_W'(signed'({1'b0, f_reg}));
        if (out_load)
            out_data_reg <= v_sat;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

`ifndef SYNTH
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input accepted while a transaction is in progress");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> phase_reg == PB'($past(phase_reg) + $past(d_in)))
        else $error("phase did not advance by the increment");

    a_blep_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        blep_start |-> !blep_status.busy)
        else $error("correction unit started while busy");

    a_blep_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        blep_status.done |-> (state_reg == pbo_pkg::ST_BLEP1 ||
                              state_reg == pbo_pkg::ST_BLEP2))
        else $error("correction result arrived with no one waiting");
`endif

endmodule
